// ===== hdl/llgb_pkg.sv =====
// ---------------------------------------------------------------------------
// llgb_pkg: shared types and constants of the lat/lon grid height binner
// Holds the word formats of both channels, command codes, the controller
// states and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package llgb_pkg;

	// Default grid size.
	localparam int DEF_MAX_ROWS    = 256;
	localparam int DEF_MAX_COLUMNS = 256;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// Field widths.
	localparam int ANGLE_W  = 24;
	localparam int HEIGHT_W = 24;
	localparam int TAG_W    = 16;
	localparam int SUM_W    = 40;
	localparam int AVG_W    = 32;

	// Two pi in Q3.20, sized to the wrapped longitude register.
	localparam logic signed [26:0] TWO_PI_Q20 = 27'sd6588397;
	localparam logic [TAG_W-1:0] COUNT_FULL = 16'hFFFF;

	// Register reset values.
	localparam logic [23:0] RST_MIN_LAT  = 24'hE6DE05;
	localparam logic [23:0] RST_MIN_LON  = 24'h000000;
	localparam logic [23:0] RST_MAX_LON  = 24'h6487ED;
	localparam logic [31:0] RST_LAT_CPR  = 32'd5308416;
	localparam logic [31:0] RST_LON_CPR  = 32'd2669914;
	localparam logic [8:0]  RST_LAT_ROWS = 9'd256;
	localparam logic [8:0]  RST_LON_COLS = 9'd256;

	// Result status codes.
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef enum logic [1:0] {
		CMD_ACCUM,
		CMD_FIRST,
		CMD_CELL,
		CMD_BILIN
	} cmd_e;

	typedef enum logic [2:0] {
		CFG_MIN_LAT,
		CFG_MIN_LON,
		CFG_MAX_LON,
		CFG_LAT_CPR,
		CFG_LON_CPR,
		CFG_LAT_ROWS,
		CFG_LON_COLS,
		CFG_WRAPS
	} cfg_reg_e;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP_UP,
		ST_WRAP_DN,
		ST_MUL_LAT,
		ST_MUL_LON,
		ST_CAP_LON,
		ST_CHECK,
		ST_READ,
		ST_LATCH,
		ST_UPDATE,
		ST_CNT_CHK,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_WMUL,
		ST_AMUL,
		ST_ACCUM,
		ST_ROUND,
		ST_FINISH
	} state_e;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		MS_LAT,
		MS_LON,
		MS_WEIGHT,
		MS_AVG
	} mul_sel_e;

	// Which value goes into the result register.
	typedef enum logic [2:0] {
		RES_NONE,
		RES_FAIL,
		RES_WRITE,
		RES_CELL,
		RES_BIL
	} res_sel_e;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic signed [ANGLE_W-1:0]  lat;
		logic signed [ANGLE_W-1:0]  lon;
		logic signed [HEIGHT_W-1:0] height_in;
		logic [TAG_W-1:0]           tag;
	} in_word_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [AVG_W-1:0] height_out;
	} out_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [TAG_W-1:0]        count;
	} cell_t;

	typedef struct packed {
		logic       load_in;
		logic       step_up;
		logic       step_dn;
		mul_sel_e   mul_sel;
		logic       cap_lat;
		logic       cap_lon;
		logic       load_idx;
		logic       cell_latch;
		logic       wr_update;
		logic       clr_en;
		logic       div_start;
		logic       avg_latch;
		logic       acc_en;
		res_sel_e   res_sel;
		logic [1:0] corner;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		cmd_e op;
		logic lon_below;
		logic lon_above;
		logic pos_ok;
		logic empty;
		logic div_done;
		logic clr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lat_lon_grid_height_binner_core.sv =====
// ---------------------------------------------------------------------------
// lat_lon_grid_height_binner_core: latitude/longitude height binning grid
// Accumulates height samples into grid cells and answers cell and bilinear
// lookups of the averaged heights.
// ---------------------------------------------------------------------------
// Usage. An input word (cmd, lat, lon, height_in, tag) is taken when
// in_valid is high and in_stall is low; every word yields exactly one
// output word (status, height_out) on out_valid/out_stall. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while no word is in work, as the block does not enforce it. Words are
// handled one at a time. After acceptance the longitude is wrapped one turn
// per cycle (0 to 7 turns), then the two grid positions go through a shared
// multiplier. A write command then reads, updates and writes back one cell.
// A cell lookup adds a count check and one division in the bit-serial
// divider; a bilinear lookup reads four cells and runs four divisions and
// four blend steps. After reset the block sweeps the whole grid to zero,
// one cell a cycle, with in_stall high; configuration writes are taken
// meanwhile. A stalled receiver keeps the output word held; one more input
// word is accepted and worked on, and waits until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module lat_lon_grid_height_binner_core #(
	parameter int MAX_ROWS    = llgb_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = llgb_pkg::DEF_MAX_COLUMNS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  llgb_pkg::in_word_t                 in_word,
	output logic                               out_valid,
	input  wire                                out_stall,
	output llgb_pkg::out_word_t                out_word,
	input  wire                                cfg_we,
	input  wire  [llgb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [llgb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	llgb_pkg::dp_cmd_t  dp_cmd;
	llgb_pkg::dp_stat_t dp_stat;

	llgb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	llgb_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

// ===== hdl/llgb_grid_mem.sv =====
// ---------------------------------------------------------------------------
// llgb_grid_mem: grid cell storage
// One write port and one read port with registered read data. Each entry
// holds a cell's height sum and sample count.
// ---------------------------------------------------------------------------
`default_nettype none

module llgb_grid_mem #(
	parameter int AW = 16
) (
	input  wire                    clk,
	input  wire                    we,
	input  wire  [AW-1:0]          waddr,
	input  llgb_pkg::cell_t        wdata,
	input  wire  [AW-1:0]          raddr,
	output llgb_pkg::cell_t        rdata
);

	llgb_pkg::cell_t cells_q [2**AW];
	llgb_pkg::cell_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			cells_q[waddr] <= wdata;
		end
	end

	// Read port, data valid in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata_q <= cells_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/llgb_div.sv =====
// ---------------------------------------------------------------------------
// llgb_div: cell average divider
// Computes sum*256/count rounded to nearest (ties away from zero) and
// saturated to 32 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module llgb_div (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire signed [llgb_pkg::SUM_W-1:0]     sum,
	input  wire        [llgb_pkg::TAG_W-1:0]     count,
	output logic signed [llgb_pkg::AVG_W-1:0]    avg,
	output logic                                 done
);

	localparam int NUM_W = llgb_pkg::SUM_W + 9;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic signed [llgb_pkg::SUM_W+7:0] scaled;
	logic [llgb_pkg::SUM_W+7:0]        mag;
	logic [NUM_W-1:0]                  num;
	logic [NUM_W-1:0]                  quo_q;
	logic [llgb_pkg::TAG_W-1:0]        rem_q;
	logic [llgb_pkg::TAG_W-1:0]        den_q;
	logic                              neg_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              busy_q;
	logic                              done_q;
	logic [llgb_pkg::TAG_W:0]          rem_sh;
	logic                              ge;
	logic [llgb_pkg::TAG_W:0]          rem_sub;
	logic                              big;

	// Magnitude of the scaled sum plus half the count gives round to nearest.
	assign scaled = {sum, 8'b0};
	assign mag    = scaled[llgb_pkg::SUM_W+7] ? (-scaled) : scaled;
	assign num    = {1'b0, mag} + {{(NUM_W - llgb_pkg::TAG_W + 1){1'b0}}, count[15:1]};

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= count;
			neg_q <= sum[llgb_pkg::SUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[llgb_pkg::TAG_W-1:0] : rem_sh[llgb_pkg::TAG_W-1:0];
		end
	end

	// Sign and saturation.
	assign big = |quo_q[NUM_W-1:31];

	always_comb begin
		if (neg_q) begin
			avg = big ? 32'sh80000000 : -$signed(quo_q[31:0]);
		end else begin
			avg = big ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

// ===== hdl/llgb_datapath.sv =====
// ---------------------------------------------------------------------------
// llgb_datapath: registers, grid memory and arithmetic of the binner
// Holds the configuration registers, the item in work, the shared
// multiplier, the bound checks, the cell average divider and the result.
// ---------------------------------------------------------------------------
`default_nettype none

module llgb_datapath #(
	parameter int MAX_ROWS    = llgb_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = llgb_pkg::DEF_MAX_COLUMNS
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [llgb_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [llgb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  llgb_pkg::in_word_t                    in_word,
	input  llgb_pkg::dp_cmd_t                     cmd,
	output llgb_pkg::dp_stat_t                    stat,
	output llgb_pkg::out_word_t                   out_word
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int AW = RW + CW;
	localparam logic [12:0] ROWS_CAP = 13'(MAX_ROWS);
	localparam logic [12:0] COLS_CAP = 13'(MAX_COLUMNS);

	// Configuration registers.
	logic [23:0] min_lat_q, min_lon_q, max_lon_q;
	logic [31:0] lat_cpr_q, lon_cpr_q;
	logic [8:0]  lat_rows_q, lon_cols_q;
	logic        wraps_q;

	// Item in work.
	llgb_pkg::cmd_e     op_q;
	logic signed [23:0] lat_q;
	logic signed [26:0] lon_q;
	logic signed [23:0] h_q;
	logic [15:0]        tag_q;
	logic signed [26:0] lon_ext;
	logic               in_is_write;

	// Multiplier.
	logic signed [24:0] lat_diff;
	logic signed [27:0] lon_diff;
	logic signed [33:0] ma;
	logic signed [32:0] mb;
	logic signed [66:0] prod_q;
	logic [16:0]        wy, wx;

	// Grid position.
	logic signed [23:0] i_q, j_q;
	logic [15:0]        fy_q, fx_q;
	logic [12:0]        rows_eff, cols_eff;
	logic signed [24:0] iv, jv, rows_s, cols_s;
	logic signed [24:0] r0, r1, c0, c1;
	logic               loc_ok, bil_ok;
	logic [RW-1:0]      row0_q, row1_q;
	logic [CW-1:0]      col0_q, col1_q;

	// Cells and memory.
	llgb_pkg::cell_t    cell_q [4];
	llgb_pkg::cell_t    cell_sel;
	llgb_pkg::cell_t    rd_data;
	llgb_pkg::cell_t    upd_cell;
	llgb_pkg::cell_t    mem_wdata;
	logic               upd_we;
	logic               full;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      clr_addr_q;
	logic signed [39:0] h_ext;

	// Averages and blend.
	logic signed [31:0] div_avg;
	logic               div_done;
	logic signed [31:0] avg_q [4];
	logic signed [31:0] avg_sel;
	logic signed [65:0] acc_q;
	logic signed [65:0] rsum;
	logic signed [33:0] rq;
	logic signed [31:0] bil_out;

	// Result.
	logic [1:0]          res_status_q;
	logic signed [31:0]  res_height_q;
	llgb_pkg::out_word_t out_word_q;

	// Configuration write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lat_q  <= llgb_pkg::RST_MIN_LAT;
			min_lon_q  <= llgb_pkg::RST_MIN_LON;
			max_lon_q  <= llgb_pkg::RST_MAX_LON;
			lat_cpr_q  <= llgb_pkg::RST_LAT_CPR;
			lon_cpr_q  <= llgb_pkg::RST_LON_CPR;
			lat_rows_q <= llgb_pkg::RST_LAT_ROWS;
			lon_cols_q <= llgb_pkg::RST_LON_COLS;
			wraps_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (llgb_pkg::cfg_reg_e'(cfg_index))
				llgb_pkg::CFG_MIN_LAT:  min_lat_q  <= cfg_data[23:0];
				llgb_pkg::CFG_MIN_LON:  min_lon_q  <= cfg_data[23:0];
				llgb_pkg::CFG_MAX_LON:  max_lon_q  <= cfg_data[23:0];
				llgb_pkg::CFG_LAT_CPR:  lat_cpr_q  <= cfg_data;
				llgb_pkg::CFG_LON_CPR:  lon_cpr_q  <= cfg_data;
				llgb_pkg::CFG_LAT_ROWS: lat_rows_q <= cfg_data[8:0];
				llgb_pkg::CFG_LON_COLS: lon_cols_q <= cfg_data[8:0];
				llgb_pkg::CFG_WRAPS:    wraps_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input word capture; write commands carry west longitude.
	assign lon_ext     = {{3{in_word.lon[23]}}, in_word.lon};
	assign in_is_write = (llgb_pkg::cmd_e'(in_word.cmd) == llgb_pkg::CMD_ACCUM) ||
	                     (llgb_pkg::cmd_e'(in_word.cmd) == llgb_pkg::CMD_FIRST);

	// Longitude is wrapped by whole turns, one turn per cycle.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= llgb_pkg::cmd_e'(in_word.cmd);
			lat_q <= in_word.lat;
			h_q   <= in_word.height_in;
			tag_q <= in_word.tag;
			lon_q <= in_is_write ? -lon_ext : lon_ext;
		end else if (cmd.step_up) begin
			lon_q <= lon_q + llgb_pkg::TWO_PI_Q20;
		end else if (cmd.step_dn) begin
			lon_q <= lon_q - llgb_pkg::TWO_PI_Q20;
		end
	end

	assign stat.lon_below = lon_q < $signed({{3{min_lon_q[23]}}, min_lon_q});
	assign stat.lon_above = lon_q >= $signed({{3{max_lon_q[23]}}, max_lon_q});

	// Shared multiplier operands.
	assign lat_diff = $signed({lat_q[23], lat_q}) - $signed({min_lat_q[23], min_lat_q});
	assign lon_diff = $signed({lon_q[26], lon_q}) - $signed({{4{min_lon_q[23]}}, min_lon_q});
	assign wy       = cmd.corner[1] ? {1'b0, fy_q} : (17'h10000 - {1'b0, fy_q});
	assign wx       = cmd.corner[0] ? {1'b0, fx_q} : (17'h10000 - {1'b0, fx_q});
	assign avg_sel  = avg_q[cmd.corner];

	always_comb begin
		case (cmd.mul_sel)
			llgb_pkg::MS_LAT: begin
				ma = {{9{lat_diff[24]}}, lat_diff};
				mb = {1'b0, lat_cpr_q};
			end
			llgb_pkg::MS_LON: begin
				ma = {{6{lon_diff[27]}}, lon_diff};
				mb = {1'b0, lon_cpr_q};
			end
			llgb_pkg::MS_WEIGHT: begin
				ma = {17'b0, wy};
				mb = {16'b0, wx};
			end
			default: begin
				ma = {1'b0, prod_q[32:0]};
				mb = {avg_sel[31], avg_sel};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// Cell index is the floor of the position; fraction bits give weights.
	always_ff @(posedge clk) begin
		if (cmd.cap_lat) begin
			i_q  <= prod_q[59:36];
			fy_q <= prod_q[35:20];
		end
		if (cmd.cap_lon) begin
			j_q  <= prod_q[59:36];
			fx_q <= prod_q[35:20];
		end
	end

	// Bound checks against the rows and columns in use.
	assign rows_eff = ({4'b0, lat_rows_q} > ROWS_CAP) ? ROWS_CAP : {4'b0, lat_rows_q};
	assign cols_eff = ({4'b0, lon_cols_q} > COLS_CAP) ? COLS_CAP : {4'b0, lon_cols_q};
	assign rows_s   = $signed({12'b0, rows_eff});
	assign cols_s   = $signed({12'b0, cols_eff});
	assign iv       = {i_q[23], i_q};
	assign jv       = {j_q[23], j_q};

	assign loc_ok = (rows_s != 25'sd0) && (iv >= 25'sd0) && (iv <= rows_s) &&
	                (jv >= 25'sd0) && (jv < cols_s);
	assign bil_ok = (rows_s >= 25'sd2) && (cols_s >= 25'sd2) && (iv >= 25'sd0) &&
	                (jv >= -25'sd1) && (iv < rows_s - 25'sd1) && (jv <= cols_s) &&
	                (wraps_q || ((jv < cols_s - 25'sd1) && (jv != -25'sd1)));
	assign stat.pos_ok = (op_q == llgb_pkg::CMD_BILIN) ? bil_ok : loc_ok;

	// Row and column pairs, with longitude wrap at the grid edges.
	always_comb begin
		r0 = iv;
		r1 = iv + 25'sd1;
		c0 = jv;
		c1 = jv + 25'sd1;
		if (op_q == llgb_pkg::CMD_BILIN) begin
			if (jv == cols_s - 25'sd1) begin
				c1 = 25'sd0;
			end else if (jv == cols_s) begin
				c0 = 25'sd0;
				c1 = 25'sd1;
			end else if (jv == -25'sd1) begin
				c0 = cols_s - 25'sd1;
				c1 = 25'sd0;
			end
		end else begin
			// A point on the top edge falls in the last row.
			if (iv == rows_s) begin
				r0 = rows_s - 25'sd1;
			end
			r1 = r0;
			c1 = jv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_idx) begin
			row0_q <= r0[RW-1:0];
			row1_q <= r1[RW-1:0];
			col0_q <= c0[CW-1:0];
			col1_q <= c1[CW-1:0];
		end
	end

	assign rd_addr = {cmd.corner[1] ? row1_q : row0_q, cmd.corner[0] ? col1_q : col0_q};

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign stat.clr_last = &clr_addr_q;

	// Latch the cells read for this item.
	always_ff @(posedge clk) begin
		if (cmd.cell_latch) begin
			cell_q[cmd.corner] <= rd_data;
		end
	end

	assign cell_sel   = cell_q[cmd.corner];
	assign stat.empty = (op_q == llgb_pkg::CMD_BILIN) ?
	                    ((cell_q[0].count == '0) || (cell_q[1].count == '0) ||
	                     (cell_q[2].count == '0) || (cell_q[3].count == '0)) :
	                    (cell_q[0].count == '0);

	// Read-modify-write of the addressed cell for the write commands.
	assign h_ext = {{16{h_q[23]}}, h_q};
	assign full  = cell_q[0].count == llgb_pkg::COUNT_FULL;

	always_comb begin
		upd_cell = cell_q[0];
		upd_we   = 1'b0;
		case (op_q)
			llgb_pkg::CMD_ACCUM: begin
				upd_we         = !full;
				upd_cell.sum   = cell_q[0].sum + h_ext;
				upd_cell.count = cell_q[0].count + 1'b1;
			end
			llgb_pkg::CMD_FIRST: begin
				upd_we         = (cell_q[0].count == '0) && (tag_q != '0);
				upd_cell.sum   = h_ext;
				upd_cell.count = tag_q;
			end
			default: ;
		endcase
	end

	assign mem_we    = cmd.clr_en || (cmd.wr_update && upd_we);
	assign mem_waddr = cmd.clr_en ? clr_addr_q : {row0_q, col0_q};
	assign mem_wdata = cmd.clr_en ? '0 : upd_cell;

	llgb_grid_mem #(
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	llgb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.sum    (cell_sel.sum),
		.count  (cell_sel.count),
		.avg    (div_avg),
		.done   (div_done)
	);

	assign stat.div_done = div_done;
	assign stat.op       = op_q;

	always_ff @(posedge clk) begin
		if (cmd.avg_latch) begin
			avg_q[cmd.corner] <= div_avg;
		end
	end

	// Weighted sum of the four averages; the first corner restarts it.
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			acc_q <= ((cmd.corner == 2'd0) ? 66'sd0 : acc_q) + prod_q[65:0];
		end
	end

	// Round half up, drop 32 fraction bits, saturate.
	assign rsum = acc_q + 66'sh80000000;
	assign rq   = rsum[65:32];

	always_comb begin
		if ((rq[33:31] == 3'b000) || (rq[33:31] == 3'b111)) begin
			bil_out = rq[31:0];
		end else if (rq[33]) begin
			bil_out = 32'sh80000000;
		end else begin
			bil_out = 32'sh7FFFFFFF;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			llgb_pkg::RES_FAIL: begin
				res_status_q <= llgb_pkg::STATUS_MISS;
				res_height_q <= '0;
			end
			llgb_pkg::RES_WRITE: begin
				res_status_q <= ((op_q == llgb_pkg::CMD_ACCUM) && full) ?
				                llgb_pkg::STATUS_FULL : llgb_pkg::STATUS_OK;
				res_height_q <= '0;
			end
			llgb_pkg::RES_CELL: begin
				res_status_q <= llgb_pkg::STATUS_OK;
				res_height_q <= div_avg;
			end
			llgb_pkg::RES_BIL: begin
				res_status_q <= llgb_pkg::STATUS_OK;
				res_height_q <= bil_out;
			end
			default: ;
		endcase
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_word_q.status     <= res_status_q;
			out_word_q.height_out <= res_height_q;
		end
	end

	assign out_word = out_word_q;

endmodule

`default_nettype wire

// ===== hdl/llgb_ctrl.sv =====
// ---------------------------------------------------------------------------
// llgb_ctrl: sequencer of the binner
// Steps one item through wrap, position, bound check, cell reads, update
// or averaging and blending, and hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module llgb_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  llgb_pkg::dp_stat_t   stat,
	output llgb_pkg::dp_cmd_t    cmd
);

	llgb_pkg::state_e state_q, state_d;
	logic [1:0]       k_q, k_d;
	logic             out_valid_q;
	logic             out_free;
	logic             is_bil;
	logic             is_write;

	assign out_free = !out_valid_q || !out_stall;
	assign is_bil   = stat.op == llgb_pkg::CMD_BILIN;
	assign is_write = (stat.op == llgb_pkg::CMD_ACCUM) || (stat.op == llgb_pkg::CMD_FIRST);

	// State and corner registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llgb_pkg::ST_CLEAR;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = state_q != llgb_pkg::ST_IDLE;

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		cmd         = '0;
		cmd.mul_sel = llgb_pkg::MS_LAT;
		cmd.res_sel = llgb_pkg::RES_NONE;
		cmd.corner  = k_q;
		unique case (state_q)
			llgb_pkg::ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_d = llgb_pkg::ST_IDLE;
				end
			end
			llgb_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = llgb_pkg::ST_WRAP_UP;
				end
			end
			llgb_pkg::ST_WRAP_UP: begin
				if (stat.lon_below) begin
					cmd.step_up = 1'b1;
				end else begin
					state_d = llgb_pkg::ST_WRAP_DN;
				end
			end
			llgb_pkg::ST_WRAP_DN: begin
				if (stat.lon_above) begin
					cmd.step_dn = 1'b1;
				end else begin
					state_d = llgb_pkg::ST_MUL_LAT;
				end
			end
			llgb_pkg::ST_MUL_LAT: begin
				cmd.mul_sel = llgb_pkg::MS_LAT;
				state_d     = llgb_pkg::ST_MUL_LON;
			end
			llgb_pkg::ST_MUL_LON: begin
				cmd.mul_sel = llgb_pkg::MS_LON;
				cmd.cap_lat = 1'b1;
				state_d     = llgb_pkg::ST_CAP_LON;
			end
			llgb_pkg::ST_CAP_LON: begin
				cmd.cap_lon = 1'b1;
				state_d     = llgb_pkg::ST_CHECK;
			end
			llgb_pkg::ST_CHECK: begin
				cmd.load_idx = 1'b1;
				k_d          = '0;
				if (!stat.pos_ok) begin
					cmd.res_sel = llgb_pkg::RES_FAIL;
					state_d     = llgb_pkg::ST_FINISH;
				end else begin
					state_d = llgb_pkg::ST_READ;
				end
			end
			llgb_pkg::ST_READ: begin
				state_d = llgb_pkg::ST_LATCH;
			end
			llgb_pkg::ST_LATCH: begin
				cmd.cell_latch = 1'b1;
				if (is_bil && (k_q != 2'd3)) begin
					k_d     = k_q + 1'b1;
					state_d = llgb_pkg::ST_READ;
				end else if (is_write) begin
					state_d = llgb_pkg::ST_UPDATE;
				end else begin
					state_d = llgb_pkg::ST_CNT_CHK;
				end
			end
			llgb_pkg::ST_UPDATE: begin
				cmd.wr_update = 1'b1;
				cmd.res_sel   = llgb_pkg::RES_WRITE;
				state_d       = llgb_pkg::ST_FINISH;
			end
			llgb_pkg::ST_CNT_CHK: begin
				k_d = '0;
				if (stat.empty) begin
					cmd.res_sel = llgb_pkg::RES_FAIL;
					state_d     = llgb_pkg::ST_FINISH;
				end else begin
					state_d = llgb_pkg::ST_DIV_START;
				end
			end
			llgb_pkg::ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = llgb_pkg::ST_DIV_WAIT;
			end
			llgb_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.avg_latch = 1'b1;
					if (is_bil && (k_q != 2'd3)) begin
						k_d     = k_q + 1'b1;
						state_d = llgb_pkg::ST_DIV_START;
					end else if (is_bil) begin
						k_d     = '0;
						state_d = llgb_pkg::ST_WMUL;
					end else begin
						cmd.res_sel = llgb_pkg::RES_CELL;
						state_d     = llgb_pkg::ST_FINISH;
					end
				end
			end
			llgb_pkg::ST_WMUL: begin
				cmd.mul_sel = llgb_pkg::MS_WEIGHT;
				state_d     = llgb_pkg::ST_AMUL;
			end
			llgb_pkg::ST_AMUL: begin
				cmd.mul_sel = llgb_pkg::MS_AVG;
				state_d     = llgb_pkg::ST_ACCUM;
			end
			llgb_pkg::ST_ACCUM: begin
				cmd.acc_en = 1'b1;
				if (k_q != 2'd3) begin
					k_d     = k_q + 1'b1;
					state_d = llgb_pkg::ST_WMUL;
				end else begin
					state_d = llgb_pkg::ST_ROUND;
				end
			end
			llgb_pkg::ST_ROUND: begin
				cmd.res_sel = llgb_pkg::RES_BIL;
				state_d     = llgb_pkg::ST_FINISH;
			end
			llgb_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = llgb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = llgb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/sv/lat_lon_grid_height_binner_core_tb.sv =====
// ---------------------------------------------------------------------------
// lat_lon_grid_height_binner_core_tb: self-checking bench of the grid binner
// Drives a directed table and then random command words through several grid
// settings and idling patterns. The bench compares each result word field by
// field with a behavioral grid model's prediction or a directed row's own.
// ---------------------------------------------------------------------------
`default_nettype none

module lat_lon_grid_height_binner_core_tb;
	import llgb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_ROWS = 256;
	localparam int GRID_COLS = 256;
	localparam int QUIET_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		cmd_e        cmd;
		int          lat;
		int          lon;
		int          hgt;
		int          tag;
		bit          typed;
		logic [1:0]  st;
		int          hout;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Bench copy of the grid and its registers.
	longint grid_sum [GRID_ROWS*GRID_COLS];
	int unsigned grid_cnt [GRID_ROWS*GRID_COLS];
	logic [31:0] reg_val [8];

	out_word_t pending_results [$];
	int fails = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	lat_lon_grid_height_binner_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Register view helpers.
	function automatic longint reg_angle(cfg_reg_e r);
		return longint'($signed(reg_val[r][23:0]));
	endfunction

	function automatic longint used_count(cfg_reg_e r, longint cap);
		longint v;
		v = longint'(reg_val[r][8:0]);
		return (v > cap) ? cap : v;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wrap_east(longint lon);
		longint lo, hi;
		lo = reg_angle(CFG_MIN_LON);
		hi = reg_angle(CFG_MAX_LON);
		while (lon < lo) lon += 6588397;
		while (lon >= hi) lon -= 6588397;
		return lon;
	endfunction

	function automatic longint grid_pos(longint ang, cfg_reg_e lo_r, cfg_reg_e cpr_r);
		return (ang - reg_angle(lo_r)) * longint'(reg_val[cpr_r]);
	endfunction

	// Cell average in Q24.8, rounded half away from zero.
	function automatic longint cell_average(int unsigned idx);
		longint s, mag, q, c;
		s = grid_sum[idx] * 256;
		c = longint'(grid_cnt[idx]);
		mag = (s < 0) ? -s : s;
		q = (mag + c / 2) / c;
		return sat32((s < 0) ? -q : q);
	endfunction

	// Cell of a point for single-cell commands; zero when out of bounds.
	function automatic bit find_cell(longint lat, longint lon, output int unsigned idx);
		longint rows, cols, i, j;
		rows = used_count(CFG_LAT_ROWS, GRID_ROWS);
		cols = used_count(CFG_LON_COLS, GRID_COLS);
		i = grid_pos(lat, CFG_MIN_LAT, CFG_LAT_CPR) >>> 36;
		j = grid_pos(wrap_east(lon), CFG_MIN_LON, CFG_LON_CPR) >>> 36;
		idx = 0;
		if (rows == 0 || i < 0 || i > rows) return 1'b0;
		if (i == rows) i = rows - 1;
		if (j < 0 || j >= cols) return 1'b0;
		idx = int'(i) * GRID_COLS + int'(j);
		return 1'b1;
	endfunction

	// Blend of the four averaged cells around a point.
	function automatic bit blend_cells(longint lat, longint lon, output longint hv);
		longint rows, cols, py, px, i, j, i2, j2, fy, fx, acc;
		int unsigned a, b, c, d;
		bit wrap;
		rows = used_count(CFG_LAT_ROWS, GRID_ROWS);
		cols = used_count(CFG_LON_COLS, GRID_COLS);
		wrap = reg_val[CFG_WRAPS][0];
		py = grid_pos(lat, CFG_MIN_LAT, CFG_LAT_CPR);
		px = grid_pos(wrap_east(lon), CFG_MIN_LON, CFG_LON_CPR);
		i = py >>> 36;
		j = px >>> 36;
		fy = (py - (i <<< 36)) >>> 20;
		fx = (px - (j <<< 36)) >>> 20;
		i2 = i + 1;
		j2 = j + 1;
		hv = 0;
		if (rows < 2 || cols < 2) return 1'b0;
		if (i < 0 || j2 < 0 || i >= rows - 1 || j > cols ||
				(j >= cols - 1 && !wrap) || (j == -1 && !wrap))
			return 1'b0;
		if (j == cols - 1) j2 = 0;
		if (j == cols) begin
			j = 0;
			j2 = 1;
		end
		if (j == -1) j = cols - 1;
		a = int'(i) * GRID_COLS + int'(j);
		b = int'(i) * GRID_COLS + int'(j2);
		c = int'(i2) * GRID_COLS + int'(j);
		d = int'(i2) * GRID_COLS + int'(j2);
		if (grid_cnt[a] == 0 || grid_cnt[b] == 0 || grid_cnt[c] == 0 || grid_cnt[d] == 0)
			return 1'b0;
		acc = (65536 - fy) * (65536 - fx) * cell_average(a)
			+ (65536 - fy) * fx * cell_average(b)
			+ fy * (65536 - fx) * cell_average(c)
			+ fy * fx * cell_average(d);
		hv = sat32((acc + (64'sd1 <<< 31)) >>> 32);
		return 1'b1;
	endfunction

	// Expected result word of one command; updates the bench grid.
	function automatic out_word_t binner_predict(in_word_t w);
		out_word_t r;
		longint lat, lon, hgt, hv;
		int unsigned idx;
		lat = longint'(w.lat);
		lon = longint'(w.lon);
		hgt = longint'(w.height_in);
		r.status = STATUS_OK;
		hv = 0;
		case (cmd_e'(w.cmd))
			CMD_ACCUM, CMD_FIRST: begin
				if (!find_cell(lat, -lon, idx)) begin
					r.status = STATUS_MISS;
				end else if (cmd_e'(w.cmd) == CMD_ACCUM) begin
					if (grid_cnt[idx] == 65535) begin
						r.status = STATUS_FULL;
					end else begin
						grid_sum[idx] += hgt;
						grid_cnt[idx]++;
					end
				end else if (grid_cnt[idx] == 0 && w.tag != 0) begin
					grid_cnt[idx] = w.tag;
					grid_sum[idx] = hgt;
				end
			end
			CMD_CELL: begin
				if (!find_cell(lat, lon, idx) || grid_cnt[idx] == 0)
					r.status = STATUS_MISS;
				else
					hv = cell_average(idx);
			end
			default: begin
				if (!blend_cells(lat, lon, hv)) begin
					r.status = STATUS_MISS;
					hv = 0;
				end
			end
		endcase
		r.height_out = hv[31:0];
		return r;
	endfunction

	function automatic bit draw(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [23:0] clamp24(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	// Offers one word with random sender gaps; called and left at a falling edge.
	task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
		out_word_t pred;
		bit taken;
		while (draw(send_idle_pct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;
		end
		pred = binner_predict(w);
		pending_results.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// Writes all eight registers back to back while the block is idle.
	task automatic write_regs(logic [31:0] vals [8]);
		for (int k = 0; k < 8; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_INDEX_W'(k);
			cfg_data <= vals[k];
			reg_val[k] = vals[k];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random command word, mostly aimed at the cells in use.
	function automatic in_word_t random_word();
		in_word_t w;
		longint rstep, cstep, rows, cols, span, lat, east;
		int pick;
		w.cmd = 2'($urandom);
		w.lat = 24'($urandom);
		w.lon = 24'($urandom);
		w.height_in = 24'($urandom);
		w.tag = 16'($urandom);
		if ($urandom_range(0, 99) < 10) return w;
		pick = $urandom_range(0, 99);
		w.cmd = (pick < 35) ? CMD_ACCUM : (pick < 55) ? CMD_FIRST :
			(pick < 75) ? CMD_CELL : CMD_BILIN;
		rstep = (reg_val[CFG_LAT_CPR] == 0) ? 1 : (64'sd1 <<< 36) / longint'(reg_val[CFG_LAT_CPR]);
		cstep = (reg_val[CFG_LON_CPR] == 0) ? 1 : (64'sd1 <<< 36) / longint'(reg_val[CFG_LON_CPR]);
		rows = used_count(CFG_LAT_ROWS, GRID_ROWS);
		cols = used_count(CFG_LON_COLS, GRID_COLS);
		if (rows < 1) rows = 1;
		if (cols < 1) cols = 1;
		span = (rows + 1) * rstep;
		if (span > (1 << 24)) span = 1 << 24;
		lat = reg_angle(CFG_MIN_LAT) - rstep / 2 + longint'($urandom_range(0, int'(span)));
		span = (cols + 1) * cstep;
		if (span > (1 << 24)) span = 1 << 24;
		east = reg_angle(CFG_MIN_LON) - cstep / 2 + longint'($urandom_range(0, int'(span)));
		w.lat = clamp24(lat);
		w.lon = (w.cmd <= CMD_FIRST) ? clamp24(-east) : clamp24(east);
		if ($urandom_range(0, 3) != 0) w.height_in = 24'($signed($urandom_range(0, 4000)) - 2000);
		if (w.tag == 0) w.tag = 16'd1;
		return w;
	endfunction

	// Directed words at the reset settings: cell (0,0) sits near lat -1647000, lon 100.
	stim_row_t dir_rows [20] = '{
		'{CMD_CELL,  -1647000,      100,        0,     0, 1, STATUS_MISS, 0},
		'{CMD_BILIN, -1647000,      100,        0,     0, 1, STATUS_MISS, 0},
		'{CMD_ACCUM, -1647000,     -100,  8388607,     0, 1, STATUS_OK,   0},
		'{CMD_ACCUM, -1647000,     -100, -8388608, 65535, 1, STATUS_OK,   0},
		'{CMD_CELL,  -1647000,      100,        0,     0, 0, STATUS_OK,   0},
		'{CMD_FIRST, -1647000,     -100,      500,     5, 1, STATUS_OK,   0},
		'{CMD_FIRST, -1647000,   -30000,      900,     0, 1, STATUS_OK,   0},
		'{CMD_FIRST, -1647000,   -30000,     1000, 65535, 1, STATUS_OK,   0},
		'{CMD_ACCUM, -1647000,   -30000,       10,     0, 1, STATUS_FULL, 0},
		'{CMD_FIRST, -1634000,     -100,       -5,     1, 1, STATUS_OK,   0},
		'{CMD_FIRST, -1634000,   -30000,       77,     3, 1, STATUS_OK,   0},
		'{CMD_BILIN, -1641000,    12000,        0,     0, 0, STATUS_OK,   0},
		'{CMD_CELL,   8388607,        0,        0,     0, 1, STATUS_MISS, 0},
		'{CMD_CELL,  -8388608,      100,        0,     0, 1, STATUS_MISS, 0},
		'{CMD_ACCUM, -8388608,  8388607,        1,     0, 1, STATUS_MISS, 0},
		'{CMD_BILIN, -1641000, -8388608,        0,     0, 0, STATUS_OK,   0},
		'{CMD_ACCUM,  1667101,     -100,       42,     0, 1, STATUS_OK,   0},
		'{CMD_CELL,   1667101,      100,        0,     0, 0, STATUS_OK,   0},
		'{CMD_BILIN, -1641000,  6588297,        0,     0, 0, STATUS_OK,   0},
		'{CMD_CELL,  -1647000,  6588497,        0,     0, 0, STATUS_OK,   0}
	};

	// Grid settings and idling of each random phase.
	logic [31:0] phase_regs [6][8] = '{
		'{-32'sd1000, -32'sd2000, 32'd6586397, 32'd67108864, 32'd67108864, 32'd4, 32'd6, 32'd1},
		'{-32'sd1000, -32'sd2000, 32'd6586397, 32'd67108864, 32'd67108864, 32'd2, 32'd2, 32'd0},
		'{-32'sd8388608, 32'd8388607, -32'sd8388608, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'd511, 32'd0, 32'd0},
		'{32'd0, 32'd0, 32'd6588397, 32'd1048576, 32'd4194304, 32'd256, 32'd256, 32'd1},
		'{32'd5000, -32'sd3000000, 32'd3588397, 32'd0, 32'd33554432, 32'd3, 32'd300, 32'd1},
		'{32'd8388000, 32'd8380000, 32'd8388607, 32'd134217728, 32'd134217728,
			32'd5, 32'd7, 32'd0}
	};
	int phase_idle [6] = '{0, 1, 2, 3, 0, 1};

	// Receiver stalls at random.
	always @(negedge clk) begin
		out_stall <= draw(recv_stall_pct);
	end

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		out_word_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected word: status %0d height %0d",
						out_word.status, out_word.height_out);
			end else begin
				want = pending_results.pop_front();
				if (want.status !== out_word.status || want.height_out !== out_word.height_out) begin
					fails++;
					if (fails <= 10)
						$display("mismatch: expected status %0d height %0d, got status %0d height %0d",
							want.status, want.height_out, out_word.status, out_word.height_out);
				end
			end
		end
	end

	// Watchdog on cycles in which no word moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("lat_lon_grid_height_binner_core_tb failed");
			$finish;
		end
	end

	initial begin
		in_word_t w;
		out_word_t typed_res;
		reg_val[CFG_MIN_LAT] = {8'hFF, RST_MIN_LAT};
		reg_val[CFG_MIN_LON] = {8'h00, RST_MIN_LON};
		reg_val[CFG_MAX_LON] = {8'h00, RST_MAX_LON};
		reg_val[CFG_LAT_CPR] = RST_LAT_CPR;
		reg_val[CFG_LON_CPR] = RST_LON_CPR;
		reg_val[CFG_LAT_ROWS] = {23'd0, RST_LAT_ROWS};
		reg_val[CFG_LON_COLS] = {23'd0, RST_LON_COLS};
		reg_val[CFG_WRAPS] = 32'd1;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset settings, no idling.
		foreach (dir_rows[k]) begin
			w.cmd = dir_rows[k].cmd;
			w.lat = 24'(dir_rows[k].lat);
			w.lon = 24'(dir_rows[k].lon);
			w.height_in = 24'(dir_rows[k].hgt);
			w.tag = 16'(dir_rows[k].tag);
			typed_res.status = dir_rows[k].st;
			typed_res.height_out = dir_rows[k].hout;
			send_word(w, dir_rows[k].typed, typed_res);
		end

		// Random phases, each under its own grid settings and idling.
		for (int p = 0; p < 6; p++) begin
			wait_drain();
			write_regs(phase_regs[p]);
			case (phase_idle[p])
				1: begin send_idle_pct = 80; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 80; end
				3: begin send_idle_pct = 7; recv_stall_pct = 7; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			@(negedge clk);
			for (int n = 0; n < 115; n++) begin
				w = random_word();
				send_word(w, 1'b0, typed_res);
			end
		end

		wait_drain();
		if (fails == 0)
			$display("lat_lon_grid_height_binner_core_tb passed");
		else
			$display("lat_lon_grid_height_binner_core_tb failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/llgb_pkg.sv
hdl/llgb_grid_mem.sv
hdl/llgb_div.sv
hdl/llgb_datapath.sv
hdl/llgb_ctrl.sv
hdl/lat_lon_grid_height_binner_core.sv
tb/sv/lat_lon_grid_height_binner_core_tb.sv
